FILE: sv/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg: shared types and constants for the sliding box mean block
// Field widths, register indexes, controller states, the divisor table
// and the structs that connect the controller to the divider.
// ----------------------------------------------------------------------------
package sbm_pkg;

   // channel field widths
   localparam int CHAN_W     = 8;    // one color channel
   localparam int GREY_W     = 10;   // red + green + blue, 0..765
   localparam int MEAN_W     = 16;   // scaled mean level
   localparam int CSR_AW     = 2;    // register index
   localparam int CSR_DW     = 11;   // widest register
   localparam int WINDOW_W   = 5;    // window_size register
   localparam int HEIGHT_W   = 11;   // image_height register
   localparam int ROW_W      = 10;   // row position
   localparam int COLSUM_W   = 14;   // column sum wraps at this width
   localparam int WSUM_W     = 18;   // window sum wraps at this width

   // clamp limits
   localparam int HEIGHT_LIMIT = 1024;
   localparam int GREY_MAX     = 765;
   localparam int WINDOW_CODES = 32;  // every value the window field can hold

   // divider widths
   localparam int DEN_W  = 20;                  // 765 * 31 * 31 fits
   localparam int NUM_W  = WSUM_W + MEAN_W;     // window sum times 65535
   localparam int CNT_W  = $clog2(MEAN_W);      // one quotient bit per cycle

   // register indexes
   localparam logic [CSR_AW-1:0] REG_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_AW-1:0] REG_IMAGE_HEIGHT = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV
   } sbm_state_type;

   // divisor 765 * N * N for each window code
   typedef logic [DEN_W-1:0] den_table_type [WINDOW_CODES];

   function automatic den_table_type build_den_table();
      den_table_type t;
      for (int i = 0; i < WINDOW_CODES; i++) begin
         t[i] = DEN_W'(GREY_MAX * i * i);
      end
      return t;
   endfunction

   localparam den_table_type DEN_TABLE = build_den_table();

   // controller to divider
   typedef struct packed {
      logic              start;
      logic [WSUM_W-1:0] window_sum;
      logic [DEN_W-1:0]  den;
   } div_req_type;

   // divider to controller
   typedef struct packed {
      logic              busy;
      logic [MEAN_W-1:0] quot;
   } div_rsp_type;

endpackage

FILE: sv/sbm_if.sv
// ----------------------------------------------------------------------------
// sbm_if: channel interfaces of the sliding box mean block
// Pixel request channel, result channel and register write channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------

// pixel channel
interface sbm_req_if
   import sbm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// result channel
interface sbm_rsp_if
   import sbm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MEAN_W-1:0] mean_level;
   logic              frame_last;

   modport source (output valid, output mean_level, output frame_last, input ready);
   modport sink   (input valid, input mean_level, input frame_last, output ready);
endinterface

// register write channel
interface sbm_csr_if
   import sbm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] addr;
   logic [CSR_DW-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

FILE: sv/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram: single-port synchronous RAM
// One address per cycle, shared by write and read; read data is registered.
// ----------------------------------------------------------------------------
module sbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sbm_div.sv
// ----------------------------------------------------------------------------
// sbm_div: scaled mean divider
// Computes floor(window_sum * 65535 / den), one quotient bit per cycle
// by restoring division, saturating at full scale.
// ----------------------------------------------------------------------------
module sbm_div
   import sbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [MEAN_W-1:0] low_ff, low_in;
   logic              sat_ff, sat_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [NUM_W-1:0]  num;
   logic [WSUM_W-1:0] num_hi;
   logic [DEN_W:0]    shifted;
   logic              ge;

   // numerator = window_sum * 65535 = (window_sum << 16) - window_sum
   assign num    = (NUM_W'(req.window_sum) << MEAN_W) - NUM_W'(req.window_sum);
   assign num_hi = num[NUM_W-1:MEAN_W];

   // one restoring step
   assign shifted = {rem_ff, low_ff[MEAN_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      sat_in  = sat_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_W'(num_hi);
         low_in  = num[MEAN_W-1:0];
         sat_in  = DEN_W'(num_hi) >= req.den;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
         low_in = {low_ff[MEAN_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MEAN_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      sat_ff <= sat_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.quot = sat_ff ? {MEAN_W{1'b1}} : low_ff;

endmodule

FILE: sv/sliding_box_mean_grey.sv
// ----------------------------------------------------------------------------
// sliding_box_mean_grey: N by N box mean of grey over an RGB pixel stream
// Column sums live in one RAM, the grey of the last N rows in another.
// Each pixel reads both, updates and writes back, updates the running
// window sum and, once the window is inside the image, divides.
//
//   channel  dir  fields                    transaction
//   req_ch   in   red, green, blue          one pixel, raster order
//   rsp_ch   out  mean_level, frame_last    one window mean
//   csr_ch   in   addr, wdata               one register write
//
// A pixel that completes no window is read from the RAMs in ST_IDLE, then
// updated and written back in ST_CALC; one that completes a window then
// waits in ST_DIV for the bit-serial divider.
// Reset is synchronous; it restores the register defaults and restarts
// the frame. A write to a known register also restarts the frame.
// A held result sits in the output register; the next pixel is taken
// meanwhile and the block stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module sliding_box_mean_grey
   import sbm_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_WINDOW = 16
) (
   input logic          clock,
   input logic          reset,
   sbm_req_if.sink      req_ch,
   sbm_rsp_if.source    rsp_ch,
   sbm_csr_if.sink      csr_ch
);

   // the window field cannot exceed 31, so deeper storage is never used
   localparam int SHIFT_DEPTH = (MAX_WINDOW < WINDOW_CODES - 1) ? MAX_WINDOW
                                                                 : WINDOW_CODES - 1;
   localparam int TAP_W       = (SHIFT_DEPTH > 1) ? $clog2(SHIFT_DEPTH) : 1;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int W_W         = $clog2(MAX_WIDTH + 1);
   localparam int LINE_DEPTH  = SHIFT_DEPTH * MAX_WIDTH;
   localparam int LINE_AW     = $clog2(LINE_DEPTH);
   localparam int W_RESET     = (MAX_WIDTH < HEIGHT_LIMIT) ? MAX_WIDTH : HEIGHT_LIMIT;

   // controller
   sbm_state_type state_ff, state_in;
   logic          req_ready, csr_ready, mem_re, mem_we, div_start, out_load;
   logic          req_fire, csr_fire, csr_known, out_free;

   // configuration
   logic [WINDOW_W-1:0] n_ff;
   logic [W_W-1:0]      w_ff;
   logic [HEIGHT_W-1:0] h_ff;
   logic [WINDOW_W-1:0] n_new;
   logic [W_W-1:0]      w_new;
   logic [HEIGHT_W-1:0] h_new;

   // position and sums
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [WINDOW_W-1:0] rmod_ff;
   logic [LINE_AW-1:0]  base_ff;
   logic [WSUM_W-1:0]   ws_ff, ws_in;
   logic [GREY_W-1:0]   grey_ff, grey_in;
   logic [COLSUM_W-1:0] tap_ff [SHIFT_DEPTH];
   logic                last_pend_ff;

   // output register
   logic                rsp_valid_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic                last_ff;

   // memories and divider
   logic [LINE_AW-1:0]  line_addr;
   logic [GREY_W-1:0]   line_rdata;
   logic [COLSUM_W-1:0] col_rdata;
   logic [COLSUM_W-1:0] cs_new;
   logic [COLSUM_W-1:0] tap_out;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // position compares
   logic col_lt_n, row_lt_n, emit, col_last, row_last, frame_last;

   assign req_fire  = req_ch.valid && req_ready;
   assign csr_fire  = csr_ch.valid && csr_ready;
   assign csr_known = (csr_ch.addr == REG_WINDOW_SIZE) || (csr_ch.addr == REG_IMAGE_WIDTH)
                      || (csr_ch.addr == REG_IMAGE_HEIGHT);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign col_lt_n   = 32'(col_ff) < 32'(n_ff);
   assign row_lt_n   = 32'(row_ff) < 32'(n_ff);
   assign emit       = !col_lt_n || (32'(col_ff) + 1 >= 32'(n_ff));
   assign col_last   = 32'(col_ff) + 1 == 32'(w_ff);
   assign row_last   = 32'(row_ff) + 1 == 32'(h_ff);
   assign frame_last = col_last && row_last;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_CALC;
         ST_CALC: begin
            if ((32'(row_ff) + 1 >= 32'(n_ff)) && emit) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: if (!div_rsp.busy && out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_ch.valid;
            mem_re    = req_ch.valid && !csr_ch.valid;
         end
         ST_CALC: begin
            mem_we    = 1'b1;
            div_start = (32'(row_ff) + 1 >= 32'(n_ff)) && emit;
         end
         ST_DIV: out_load = !div_rsp.busy && out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = csr_ready;

   // register clamping
   always_comb begin
      n_new = csr_ch.wdata[WINDOW_W-1:0];
      if (csr_ch.wdata[WINDOW_W-1:0] == '0) begin
         n_new = WINDOW_W'(1);
      end else if (32'(csr_ch.wdata[WINDOW_W-1:0]) > MAX_WINDOW) begin
         n_new = WINDOW_W'(MAX_WINDOW);
      end
      w_new = W_W'(csr_ch.wdata);
      if (csr_ch.wdata == '0) begin
         w_new = W_W'(1);
      end else if (32'(csr_ch.wdata) > MAX_WIDTH) begin
         w_new = W_W'(MAX_WIDTH);
      end
      h_new = HEIGHT_W'(csr_ch.wdata);
      if (csr_ch.wdata == '0) begin
         h_new = HEIGHT_W'(1);
      end else if (32'(csr_ch.wdata) > HEIGHT_LIMIT) begin
         h_new = HEIGHT_W'(HEIGHT_LIMIT);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= WINDOW_W'(1);
         w_ff <= W_W'(W_RESET);
         h_ff <= HEIGHT_W'(HEIGHT_LIMIT);
      end else if (csr_fire) begin
         unique case (csr_ch.addr)
            REG_WINDOW_SIZE:  n_ff <= n_new;
            REG_IMAGE_WIDTH:  w_ff <= w_new;
            REG_IMAGE_HEIGHT: h_ff <= h_new;
            default: ;
         endcase
      end
   end

   // grey level of the accepted pixel
   assign grey_in = GREY_W'(req_ch.red) + GREY_W'(req_ch.green) + GREY_W'(req_ch.blue);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         grey_ff <= grey_in;
      end
   end

   // line store slot = (row mod N) * MAX_WIDTH + col
   assign line_addr = base_ff + LINE_AW'(col_ff);

   sbm_ram #(
      .WIDTH (GREY_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (line_addr),
      .wdata (grey_ff),
      .rdata (line_rdata)
   );

   sbm_ram #(
      .WIDTH (COLSUM_W),
      .DEPTH (MAX_WIDTH)
   ) u_col_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (col_ff),
      .wdata (cs_new),
      .rdata (col_rdata)
   );

   // column sum over the last N rows
   always_comb begin
      if (row_ff == '0) begin
         cs_new = COLSUM_W'(grey_ff);
      end else if (row_lt_n) begin
         cs_new = col_rdata + COLSUM_W'(grey_ff);
      end else begin
         cs_new = col_rdata + COLSUM_W'(grey_ff) - COLSUM_W'(line_rdata);
      end
   end

   // column sum that leaves the window, written N pixels ago on this row
   assign tap_out = tap_ff[TAP_W'(n_ff - 1'b1)];

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         tap_ff[0] <= cs_new;
         for (int i = 1; i < SHIFT_DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   // window sum over the last N columns
   always_comb begin
      if (col_ff == '0) begin
         ws_in = WSUM_W'(cs_new);
      end else if (col_lt_n) begin
         ws_in = ws_ff + WSUM_W'(cs_new);
      end else begin
         ws_in = ws_ff + WSUM_W'(cs_new) - WSUM_W'(tap_out);
      end
   end

   // positions and window sum; a write to a known register restarts the frame
   always_ff @(posedge clock) begin
      if (reset || (csr_fire && csr_known)) begin
         col_ff  <= '0;
         row_ff  <= '0;
         rmod_ff <= '0;
         base_ff <= '0;
         ws_ff   <= '0;
      end else if (state_ff == ST_CALC) begin
         ws_ff <= ws_in;
         if (col_last) begin
            col_ff <= '0;
            if (row_last) begin
               row_ff  <= '0;
               rmod_ff <= '0;
               base_ff <= '0;
            end else begin
               row_ff <= row_ff + 1'b1;
               if (rmod_ff + 1'b1 == n_ff) begin
                  rmod_ff <= '0;
                  base_ff <= '0;
               end else begin
                  rmod_ff <= rmod_ff + 1'b1;
                  base_ff <= base_ff + LINE_AW'(MAX_WIDTH);
               end
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // frame_last travels with the division
   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         last_pend_ff <= frame_last;
      end
   end

   // divider
   assign div_req.start      = div_start;
   assign div_req.window_sum = ws_in;
   assign div_req.den        = DEN_TABLE[n_ff];

   sbm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mean_ff <= div_rsp.quot;
         last_ff <= last_pend_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mean_level = mean_ff;
   assign rsp_ch.frame_last = last_ff;

endmodule

FILE: tb/sv/tb_sliding_box_mean_grey.sv
// ----------------------------------------------------------------------------
// tb_sliding_box_mean_grey: self-checking bench for the sliding box mean block
// Streams RGB pixels through the block under several window and image
// geometries. A local predictor mirrors the column sums, the running box
// sum and the scaled mean, and every result transaction is compared field
// by field against the oldest predicted mean. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_sliding_box_mean_grey;
   import sbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS     = 1024;
   localparam int MAX_SIDE     = 16;
   localparam int FULL_SCALE   = 65535;
   localparam int IDLE_PAUSE   = 24;     // lets a completing pixel's division finish
   localparam int QUIET_LIMIT  = 2000;   // longest correct quiet stretch is the hold-off
   localparam int RANDOM_ITEMS = 230;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_t;

   typedef struct {
      logic [MEAN_W-1:0] level;
      logic              last;
   } mean_result_t;

   logic clock;
   logic reset;

   sbm_req_if req_bus ();
   sbm_rsp_if rsp_bus ();
   sbm_csr_if csr_bus ();

   sliding_box_mean_grey #(
      .MAX_WIDTH  (MAX_COLS),
      .MAX_WINDOW (MAX_SIDE)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state
   logic [WINDOW_W-1:0] cfg_window;
   logic [CSR_DW-1:0]   cfg_width;
   logic [CSR_DW-1:0]   cfg_height;
   logic [GREY_W-1:0]   grey_rows [MAX_SIDE * MAX_COLS];
   logic [COLSUM_W-1:0] column_totals [MAX_COLS];
   logic [WSUM_W-1:0]   box_total;
   int unsigned         x_pos;
   int unsigned         y_pos;

   mean_result_t pending_means [$];
   int unsigned  errors;
   int unsigned  rsp_holdoff;
   bit           req_gaps_on;
   bit           rsp_gaps_on;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic int unsigned clamp_code(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void restart_frame();
      box_total = '0;
      x_pos     = 0;
      y_pos     = 0;
   endfunction

   function automatic void reset_model();
      cfg_window = WINDOW_W'(1);
      cfg_width  = CSR_DW'(1024);
      cfg_height = CSR_DW'(1024);
      foreach (grey_rows[i]) grey_rows[i] = '0;
      foreach (column_totals[i]) column_totals[i] = '0;
      restart_frame();
   endfunction

   function automatic void apply_register(input logic [CSR_AW-1:0] idx,
                                          input logic [CSR_DW-1:0] val);
      case (idx)
         REG_WINDOW_SIZE: begin
            cfg_window = val[WINDOW_W-1:0];
            restart_frame();
         end
         REG_IMAGE_WIDTH: begin
            cfg_width = val;
            restart_frame();
         end
         REG_IMAGE_HEIGHT: begin
            cfg_height = val;
            restart_frame();
         end
         default: ;
      endcase
   endfunction

   // one pixel in; queues the window mean it completes, if any
   function automatic void predict_mean(input pixel_t px);
      int unsigned     n, w, h, c, r, grey, slot;
      longint unsigned scaled;
      mean_result_t    res;
      n = clamp_code(cfg_window, MAX_SIDE);
      w = clamp_code(cfg_width, MAX_COLS);
      h = clamp_code(cfg_height, HEIGHT_LIMIT);
      c = (x_pos >= w) ? w - 1 : x_pos;
      r = (y_pos >= h) ? h - 1 : y_pos;
      grey = px.red + px.green + px.blue;
      slot = (r % n) * MAX_COLS + c;

      // column total over the last n rows, wraps at its width
      if (r == 0)
         column_totals[c] = COLSUM_W'(grey);
      else if (r < n)
         column_totals[c] = column_totals[c] + grey;
      else
         column_totals[c] = column_totals[c] + grey - grey_rows[slot];
      grey_rows[slot] = GREY_W'(grey);

      // box total over the last n columns
      if (c == 0)
         box_total = column_totals[0];
      else if (c < n)
         box_total = box_total + column_totals[c];
      else
         box_total = box_total + column_totals[c] - column_totals[c - n];

      if (r + 1 >= n && c + 1 >= n) begin
         scaled = (64'(box_total) * FULL_SCALE) / (GREY_MAX * n * n);
         if (scaled > FULL_SCALE) scaled = FULL_SCALE;
         res.level = MEAN_W'(scaled);
         res.last  = (r == h - 1 && c == w - 1);
         pending_means.push_back(res);
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      x_pos = c;
      y_pos = r;
   endfunction

   // ------------------------------------------------------------------
   // shared stimulus helpers
   // ------------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic pixel_t random_pixel();
      pixel_t px;
      case ($urandom_range(0, 9))
         0: px = '{8'd0, 8'd0, 8'd0};
         1: px = '{8'd255, 8'd255, 8'd255};
         default: begin
            px.red   = CHAN_W'($urandom);
            px.green = CHAN_W'($urandom);
            px.blue  = CHAN_W'($urandom);
         end
      endcase
      return px;
   endfunction

   // one pixel transaction; valid stays high for a back-to-back follower
   task automatic send_pixel(input pixel_t px);
      int unsigned gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= px.red;
      req_bus.green <= px.green;
      req_bus.blue  <= px.blue;
      do @(posedge clock); while (!req_bus.ready);
      predict_mean(px);
   endtask

   task automatic send_pixels(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // stop sending, let every expected mean arrive, then let the pipe empty
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   // write all three registers back to back while the block is idle
   task automatic set_geometry(input int unsigned n_code, input int unsigned w_code,
                               input int unsigned h_code);
      logic [CSR_AW-1:0] idx [3];
      logic [CSR_DW-1:0] val [3];
      wait_idle();
      idx = '{REG_WINDOW_SIZE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
      val = '{CSR_DW'(WINDOW_W'(n_code)), CSR_DW'(w_code), CSR_DW'(h_code)};
      for (int i = 0; i < 3; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.addr  <= idx[i];
         csr_bus.wdata <= val[i];
         do @(posedge clock); while (!csr_bus.ready);
         apply_register(idx[i], val[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset geometry: 1x1 window, every pixel gives its own mean
   task automatic test_reset_defaults();
      send_pixel('{8'd0, 8'd0, 8'd0});
      send_pixel('{8'd255, 8'd255, 8'd255});
      send_pixel('{8'd255, 8'd0, 8'd1});
   endtask

   // out-of-range register codes clamp
   task automatic test_register_clamps();
      set_geometry(31, 2047, 3);   // window 16 over a 3-row image: nothing out
      send_pixels(4);
      set_geometry(1, 3, 2047);    // height clamps to the limit
      send_pixels(3);
      set_geometry(0, 0, 0);       // 1x1 image, every pixel ends a frame
      send_pixels(3);
   endtask

   // window larger than the image: frames still wrap, nothing comes out
   task automatic test_window_over_image();
      set_geometry(3, 2, 2);
      send_pixels(6);
   endtask

   // last window flag and wrap into the next frame
   task automatic test_frame_end();
      set_geometry(2, 3, 2);
      send_pixel('{8'd255, 8'd255, 8'd255});
      send_pixel('{8'd0, 8'd0, 8'd0});
      send_pixels(5);
   endtask

   // biggest window over a white frame: full-scale sums and mean
   task automatic test_largest_window();
      set_geometry(16, 16, 16);
      repeat (256) send_pixel('{8'd255, 8'd255, 8'd255});
   endtask

   // receiver holds off while pixels keep coming, then the results drain
   task automatic test_output_backpressure();
      set_geometry(1, 5, 4);
      req_gaps_on = 1'b0;
      rsp_holdoff = 200;
      send_pixels(40);
      wait_idle();
      req_gaps_on = 1'b1;
   endtask

   // random geometries, mostly small, with random pixel content
   task automatic test_random_geometry();
      int unsigned done_items, n, w, h, count, frame;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         n = $urandom_range(1, 4);
         w = $urandom_range(n, n + 6);
         h = $urandom_range(n, n + 4);
         case ($urandom_range(0, 19))
            0: n = 0;
            1: begin   // no window ever fits
               n = $urandom_range(3, 8);
               w = $urandom_range(1, n - 1);
            end
            2: begin   // width zero or past the limit
               n = 1;
               w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1025, 2047);
               h = $urandom_range(1, 3);
            end
            3: begin   // bigger windows, one to two frames and part of a row, at most 90 pixels
               n = $urandom_range(5, 7);
               w = $urandom_range(n, n + 2);
               h = $urandom_range(n, n + 1);
            end
            4: begin   // height zero or past the limit
               n = $urandom_range(1, 2);
               h = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1025, 2047);
            end
            default: ;
         endcase
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         set_geometry(n, w, h);
         frame = clamp_code(w, MAX_COLS) * clamp_code(h, HEIGHT_LIMIT);
         count = frame * $urandom_range(1, 2) + $urandom_range(0, clamp_code(w, MAX_COLS));
         if (count > 90) count = $urandom_range(50, 90);
         send_pixels(count);
         done_items += count;
      end
   endtask

   // ------------------------------------------------------------------
   // result side: ready pacing and checking
   // ------------------------------------------------------------------
   initial begin : rsp_pacing
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_holdoff != 0) begin
            rsp_holdoff--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_gaps_on) stall_left = pick_gap();
         end
      end
   end

   // compare each result transaction with the oldest predicted mean
   always @(posedge clock) begin : check_means
      mean_result_t want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_means.size() == 0) begin
            $error("unexpected result: mean_level %0d frame_last %0b",
                   rsp_bus.mean_level, rsp_bus.frame_last);
            errors++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_bus.mean_level !== want.level) begin
               $error("mean_level: expected %0d, actual %0d", want.level, rsp_bus.mean_level);
               errors++;
            end
            if (rsp_bus.frame_last !== want.last) begin
               $error("frame_last: expected %0b, actual %0b", want.last, rsp_bus.frame_last);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no transaction on any channel
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      errors      = 0;
      rsp_holdoff = 0;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      reset_model();
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      req_bus.blue  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.addr  <= REG_WINDOW_SIZE;
      csr_bus.wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_clamps();
      test_window_over_image();
      test_frame_end();
      test_largest_window();
      test_output_backpressure();
      test_random_geometry();
      wait_idle();

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
